// ----- src/pbcs_pkg.sv -----
package pbcs_pkg;

  localparam int MaxEntry   = 63;
  localparam int NumRecords = MaxEntry + 1;
  localparam int RecBytes   = 24;
  localparam int RegBytes   = 9;
  localparam int NameStart  = 8;
  localparam int StoreBytes = NumRecords * RecBytes;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int RecW       = (NumRecords > 1) ? $clog2(NumRecords) : 1;
  localparam int IdxW       = $clog2(RecBytes);
  // The write position saturates one above the record length.
  localparam int PosW       = $clog2(RecBytes + 2);
  localparam int FifoDepth  = 2;

  localparam logic [7:0] BlankChar = 8'd32;
  localparam logic [7:0] StatusOk  = 8'h84;
  localparam logic [7:0] StatusErr = 8'hC4;
  localparam logic [7:0] TopBit    = 8'h80;
  localparam logic [7:0] EraseByte = 8'hFF;

  typedef enum logic [2:0] {
    CMD_READ_RECORD  = 3'd0,
    CMD_WRITE_RECORD = 3'd1,
    CMD_READ_REG     = 3'd2,
    CMD_ADD_CHARGE   = 3'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_READ,
    OP_COMMIT,
    OP_REGS,
    OP_STATUS
  } op_kind_e;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RD_REQ,
    B_RD_DATA,
    B_CP_WRITE,
    B_HDR_REQ,
    B_HDR_DATA,
    B_REG_EMIT,
    B_STATUS
  } back_state_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [RecW-1:0]       record;
    logic                  ok;
    logic                  blank;
  } op_t;

  typedef struct packed {
    logic clearing;
    logic commit_done;
  } back_status_t;

endpackage

// ----- src/pbcs_fifo.sv -----
module pbcs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pbcs_pkg::op_t    op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output pbcs_pkg::op_t    op_o
);

  localparam int PtrW = (pbcs_pkg::FifoDepth > 1) ? $clog2(pbcs_pkg::FifoDepth) : 1;
  localparam int CntW = $clog2(pbcs_pkg::FifoDepth + 1);

  pbcs_pkg::op_t   mem_q [pbcs_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(pbcs_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(pbcs_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(pbcs_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  overflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("command queue overflow");

  underflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");

endmodule

// ----- src/pbcs_front.sv -----
module pbcs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic [7:0]                  record_i,
  input  logic [7:0]                  data_byte_i,
  input  logic                        last_i,
  output logic                        push_o,
  output pbcs_pkg::op_t               op_o,
  input  logic                        fifo_full_i,
  input  pbcs_pkg::back_status_t      back_st_i,
  input  logic [pbcs_pkg::IdxW-1:0]   stg_idx_i,
  output logic [7:0]                  stg_data_o
);

  logic [7:0]                staging_q [pbcs_pkg::RecBytes];
  logic [pbcs_pkg::PosW-1:0] wpos_q, wpos_d;
  logic [pbcs_pkg::PosW-1:0] wpos_inc;
  logic                      pend_commit_q, pend_commit_d;
  logic                      accept;
  logic                      stg_we;
  logic                      rec_high;

  assign in_ready_o = !fifo_full_i && !pend_commit_q && !back_st_i.clearing;
  assign accept     = in_valid_i && in_ready_o;
  assign rec_high   = (record_i > 8'(pbcs_pkg::MaxEntry));
  assign stg_data_o = staging_q[stg_idx_i];
  assign wpos_inc   = (wpos_q < pbcs_pkg::PosW'(pbcs_pkg::RecBytes + 1)) ?
                      wpos_q + 1'b1 : wpos_q;

  always_comb begin
    wpos_d      = wpos_q;
    stg_we      = 1'b0;
    push_o      = 1'b0;
    op_o.kind   = pbcs_pkg::OP_STATUS;
    op_o.record = record_i[pbcs_pkg::RecW-1:0];
    op_o.ok     = 1'b1;
    op_o.blank  = 1'b0;
    if (accept) begin
      if (cmd_i == pbcs_pkg::CMD_WRITE_RECORD) begin
        stg_we = (wpos_q < pbcs_pkg::PosW'(pbcs_pkg::RecBytes));
        wpos_d = wpos_inc;
        if (last_i) begin
          wpos_d = '0;
          push_o = 1'b1;
          if ((wpos_inc != pbcs_pkg::PosW'(pbcs_pkg::RecBytes)) || rec_high) begin
            op_o.ok = 1'b0;
          end else begin
            // A complete record always has its name byte staged already.
            op_o.kind  = pbcs_pkg::OP_COMMIT;
            op_o.blank = (staging_q[pbcs_pkg::NameStart] == pbcs_pkg::BlankChar);
          end
        end
      end else begin
        wpos_d = '0;
        push_o = 1'b1;
        case (pbcs_pkg::cmd_e'(cmd_i))
          pbcs_pkg::CMD_READ_RECORD: begin
            if (rec_high) begin
              op_o.ok = 1'b0;
            end else begin
              op_o.kind = pbcs_pkg::OP_READ;
            end
          end
          pbcs_pkg::CMD_READ_REG: begin
            op_o.kind = pbcs_pkg::OP_REGS;
          end
          pbcs_pkg::CMD_ADD_CHARGE: begin
            op_o.ok = 1'b1;
          end
          default: begin
            op_o.ok = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    pend_commit_d = pend_commit_q;
    if (push_o && op_o.kind == pbcs_pkg::OP_COMMIT) begin
      pend_commit_d = 1'b1;
    end else if (back_st_i.commit_done) begin
      pend_commit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q        <= '0;
      pend_commit_q <= 1'b0;
    end else begin
      wpos_q        <= wpos_d;
      pend_commit_q <= pend_commit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      staging_q[wpos_q[pbcs_pkg::IdxW-1:0]] <= data_byte_i;
    end
  end

  staging_guard_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_commit_q |-> !stg_we)
    else $error("staging written while a commit is outstanding");

endmodule

// ----- src/pbcs_back.sv -----
module pbcs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_empty_i,
  input  pbcs_pkg::op_t               fifo_op_i,
  output logic                        pop_o,
  output pbcs_pkg::back_status_t      back_st_o,
  output logic [pbcs_pkg::IdxW-1:0]   stg_idx_o,
  input  logic [7:0]                  stg_data_i,
  input  logic [63:0]                 reg_low_i,
  input  logic [7:0]                  reg_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        has_data_o,
  output logic [7:0]                  data_out_o,
  output logic [7:0]                  status_o,
  output logic                        end_of_response_o
);

  localparam int AW = pbcs_pkg::AddrW;

  pbcs_pkg::back_state_e     state_q, state_d;
  pbcs_pkg::op_t             op_q, op_d;
  logic [pbcs_pkg::IdxW-1:0] idx_q, idx_d;
  logic [AW-1:0]             clr_q, clr_d;

  logic [7:0]    mem_q [pbcs_pkg::StoreBytes];
  logic [7:0]    rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic          out_valid_q;
  logic          out_has_data_q;
  logic [7:0]    out_data_q;
  logic [7:0]    out_status_q;
  logic          out_end_q;
  logic          out_free;
  logic          out_load;
  logic          ld_has_data;
  logic [7:0]    ld_data;
  logic [7:0]    ld_status;
  logic          ld_end;

  logic [AW-1:0] base_addr;
  logic [7:0]    entry;
  logic [AW-1:0] hdr_addr;
  logic [7:0]    hdr_mask;
  logic [7:0]    reg_byte;
  logic          last_rec_byte;
  logic          last_reg_byte;

  assign out_free      = !out_valid_q || out_ready_i;
  assign base_addr     = AW'(op_q.record) * AW'(pbcs_pkg::RecBytes);
  assign entry         = 8'(op_q.record) - 8'd1;
  // Entry n owns bit (n-1) of the bitmap, counted MSB first from header byte 1.
  assign hdr_addr      = AW'(1) + AW'(entry >> 3);
  assign hdr_mask      = pbcs_pkg::TopBit >> entry[2:0];
  assign last_rec_byte = (idx_q == pbcs_pkg::IdxW'(pbcs_pkg::RecBytes - 1));
  assign last_reg_byte = (idx_q == pbcs_pkg::IdxW'(pbcs_pkg::RegBytes - 1));
  assign reg_byte      = last_reg_byte ? reg_last_i : 8'(reg_low_i >> {idx_q[2:0], 3'b000});
  assign stg_idx_o     = idx_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    clr_d   = clr_q;
    pop_o   = 1'b0;
    case (state_q)
      pbcs_pkg::B_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(pbcs_pkg::StoreBytes - 1)) begin
          state_d = pbcs_pkg::B_IDLE;
        end
      end
      pbcs_pkg::B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          op_d  = fifo_op_i;
          idx_d = '0;
          case (fifo_op_i.kind)
            pbcs_pkg::OP_READ:   state_d = pbcs_pkg::B_RD_REQ;
            pbcs_pkg::OP_REGS:   state_d = pbcs_pkg::B_REG_EMIT;
            pbcs_pkg::OP_COMMIT: begin
              if (!fifo_op_i.blank) begin
                state_d = pbcs_pkg::B_CP_WRITE;
              end else if (fifo_op_i.record != '0) begin
                state_d = pbcs_pkg::B_HDR_REQ;
              end else begin
                state_d = pbcs_pkg::B_STATUS;
              end
            end
            default:             state_d = pbcs_pkg::B_STATUS;
          endcase
        end
      end
      pbcs_pkg::B_RD_REQ: begin
        state_d = pbcs_pkg::B_RD_DATA;
      end
      pbcs_pkg::B_RD_DATA: begin
        if (out_free) begin
          if (last_rec_byte) begin
            state_d = pbcs_pkg::B_STATUS;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = pbcs_pkg::B_RD_REQ;
          end
        end
      end
      pbcs_pkg::B_CP_WRITE: begin
        if (last_rec_byte) begin
          state_d = (op_q.record != '0) ? pbcs_pkg::B_HDR_REQ : pbcs_pkg::B_STATUS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      pbcs_pkg::B_HDR_REQ: begin
        state_d = pbcs_pkg::B_HDR_DATA;
      end
      pbcs_pkg::B_HDR_DATA: begin
        state_d = pbcs_pkg::B_STATUS;
      end
      pbcs_pkg::B_REG_EMIT: begin
        if (out_free) begin
          if (last_reg_byte) begin
            state_d = pbcs_pkg::B_STATUS;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      pbcs_pkg::B_STATUS: begin
        if (out_free) begin
          state_d = pbcs_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = pbcs_pkg::B_IDLE;
      end
    endcase
  end

  // Outputs of each state.
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = base_addr + AW'(idx_q);
    mem_raddr   = base_addr + AW'(idx_q);
    mem_wdata   = stg_data_i;
    out_load    = 1'b0;
    ld_has_data = 1'b1;
    ld_data     = 8'd0;
    ld_status   = 8'd0;
    ld_end      = 1'b0;
    back_st_o.clearing    = 1'b0;
    back_st_o.commit_done = 1'b0;
    case (state_q)
      pbcs_pkg::B_CLEAR: begin
        back_st_o.clearing = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = pbcs_pkg::EraseByte;
      end
      pbcs_pkg::B_RD_REQ: begin
        mem_re = 1'b1;
      end
      pbcs_pkg::B_RD_DATA: begin
        out_load = out_free;
        ld_data  = rdata_q;
      end
      pbcs_pkg::B_CP_WRITE: begin
        mem_we = 1'b1;
      end
      pbcs_pkg::B_HDR_REQ: begin
        mem_re    = 1'b1;
        mem_raddr = hdr_addr;
      end
      pbcs_pkg::B_HDR_DATA: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_addr;
        mem_wdata = op_q.blank ? (rdata_q | hdr_mask) : (rdata_q & ~hdr_mask);
      end
      pbcs_pkg::B_REG_EMIT: begin
        out_load = out_free;
        ld_data  = reg_byte;
      end
      pbcs_pkg::B_STATUS: begin
        out_load    = out_free;
        ld_has_data = 1'b0;
        ld_end      = 1'b1;
        ld_status   = (op_q.kind == pbcs_pkg::OP_STATUS && !op_q.ok) ?
                      pbcs_pkg::StatusErr : pbcs_pkg::StatusOk;
        // Released once, as the status beat is loaded for output, so a later commit keeps its hold.
        back_st_o.commit_done = (op_q.kind == pbcs_pkg::OP_COMMIT) && out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbcs_pkg::B_CLEAR;
      idx_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (out_load) begin
      out_has_data_q <= ld_has_data;
      out_data_q     <= ld_data;
      out_status_q   <= ld_status;
      out_end_q      <= ld_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign has_data_o        = out_has_data_q;
  assign data_out_o        = out_data_q;
  assign status_o          = out_status_q;
  assign end_of_response_o = out_end_q;

  clear_quiet_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbcs_pkg::B_CLEAR) |-> !out_valid_q)
    else $error("response beat during the clearing pass");

  copy_only_commit_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbcs_pkg::B_CP_WRITE) |->
      (op_q.kind == pbcs_pkg::OP_COMMIT && !op_q.blank))
    else $error("record copy without a committing write");

  status_closes_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbcs_pkg::B_STATUS && out_free) |=>
      (state_q == pbcs_pkg::B_IDLE && out_valid_q && out_end_q && !out_has_data_q))
    else $error("status beat did not close the command");

endmodule

// ----- src/phonebook_card_command_store.sv -----
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o  cmd_i, record_i, data_byte_i, last_i
// out       output     out_valid_o / out_ready_i has_data_o, data_out_o, status_o,
//                                               end_of_response_o
// cfg       input      psel, penable, pwrite    paddr, pwdata, prdata (pready tied high)
//
// After reset the record store is erased by a clearing pass over all 1536 bytes, one
// byte a cycle through the memory write port; no command beat is taken until it ends.
// A write_record beat is staged as it is accepted. A valid read_record emits the 24 record
// bytes, each after a registered memory read; a commit copies the 24 staged bytes
// (not for a blank name) and, for a record other than 0, reads and rewrites its bitmap
// byte; read_registration emits 9 bytes. Every command ends with a status beat.
// A stalled response holds the back end; the front end keeps queueing up to two
// commands but waits while a commit still owns the staging buffer.
module phonebook_card_command_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  record_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_data_o,
  output logic [7:0]  data_out_o,
  output logic [7:0]  status_o,
  output logic        end_of_response_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] reg_low_q;
  logic [7:0]  reg_last_q;
  logic        cfg_write;

  logic                      push;
  logic                      pop;
  logic                      fifo_full;
  logic                      fifo_empty;
  pbcs_pkg::op_t             front_op;
  pbcs_pkg::op_t             fifo_op;
  pbcs_pkg::back_status_t    back_st;
  logic [pbcs_pkg::IdxW-1:0] stg_idx;
  logic [7:0]                stg_data;

  // Registers sit 8 bytes apart, so only address bit 3 selects one.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = paddr[3] ? {56'd0, reg_last_q} : reg_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_low_q  <= '0;
      reg_last_q <= '0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        reg_last_q <= pwdata[7:0];
      end else begin
        reg_low_q <= pwdata;
      end
    end
  end

  pbcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .record_i    (record_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .push_o      (push),
    .op_o        (front_op),
    .fifo_full_i (fifo_full),
    .back_st_i   (back_st),
    .stg_idx_i   (stg_idx),
    .stg_data_o  (stg_data)
  );

  pbcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .op_o    (fifo_op)
  );

  pbcs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fifo_empty_i      (fifo_empty),
    .fifo_op_i         (fifo_op),
    .pop_o             (pop),
    .back_st_o         (back_st),
    .stg_idx_o         (stg_idx),
    .stg_data_i        (stg_data),
    .reg_low_i         (reg_low_q),
    .reg_last_i        (reg_last_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .has_data_o        (has_data_o),
    .data_out_o        (data_out_o),
    .status_o          (status_o),
    .end_of_response_o (end_of_response_o)
  );

endmodule

// ----- verif/phonebook_reply_checker.sv -----
`timescale 1ns / 1ps

module phonebook_reply_checker
  import pbcs_pkg::*;
#(
  parameter logic [3:0] RegLowAddr  = 4'd0,
  parameter logic [3:0] RegLastAddr = 4'd8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  record_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        has_data_i,
  input  logic [7:0]  data_out_i,
  input  logic [7:0]  status_i,
  input  logic        end_of_response_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatches_o,
  output int          replies_pending_o
);

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_out;
    logic [7:0] status;
    logic       end_of_response;
  } reply_t;

  logic [7:0]  card_store [StoreBytes];
  logic [7:0]  staged_bytes [RecBytes];
  int          staged_count;
  logic [63:0] reg_bytes_low;
  logic [7:0]  reg_byte_last;
  reply_t      replies_due [$];
  reply_t      oldest_reply;

  function automatic reply_t data_reply(logic [7:0] value);
    return '{1'b1, value, 8'h00, 1'b0};
  endfunction

  function automatic reply_t status_reply(logic [7:0] code);
    return '{1'b0, 8'h00, code, 1'b1};
  endfunction

  // Header bytes from 1 onward hold one bit per entry, most significant bit first;
  // a cleared bit marks the entry as used.
  task automatic mark_occupancy(input int rec, input bit used);
    int         idx;
    int         hdr;
    logic [7:0] mask;
    if (rec == 0) return;
    idx = rec - 1;
    hdr = 1 + idx / 8;
    if (hdr >= RecBytes) return;
    mask = TopBit >> (idx % 8);
    if (used) card_store[hdr] = card_store[hdr] & ~mask;
    else card_store[hdr] = card_store[hdr] | mask;
  endtask

  task automatic take_card_beat(input logic [2:0] cmd, input logic [7:0] rec,
                                input logic [7:0] db, input logic lst);
    int n;
    int i;
    int base;
    base = int'(rec) * RecBytes;
    if (cmd != CMD_WRITE_RECORD) staged_count = 0;
    case (cmd)
      CMD_READ_RECORD: begin
        if (rec > MaxEntry) begin
          replies_due.push_back(status_reply(StatusErr));
        end else begin
          for (i = 0; i < RecBytes; i++) replies_due.push_back(data_reply(card_store[base + i]));
          replies_due.push_back(status_reply(StatusOk));
        end
      end
      CMD_WRITE_RECORD: begin
        if (staged_count < RecBytes) staged_bytes[staged_count] = db;
        if (staged_count < RecBytes + 1) staged_count++;
        if (lst) begin
          n = staged_count;
          staged_count = 0;
          if (n != RecBytes || rec > MaxEntry) begin
            replies_due.push_back(status_reply(StatusErr));
          end else begin
            // A blank first name character frees the entry in the bitmap instead of storing it.
            if (staged_bytes[NameStart] != BlankChar) begin
              for (i = 0; i < RecBytes; i++) card_store[base + i] = staged_bytes[i];
              mark_occupancy(int'(rec), 1'b1);
            end else begin
              mark_occupancy(int'(rec), 1'b0);
            end
            replies_due.push_back(status_reply(StatusOk));
          end
        end
      end
      CMD_READ_REG: begin
        for (i = 0; i < RegBytes - 1; i++) replies_due.push_back(data_reply(reg_bytes_low[8*i +: 8]));
        replies_due.push_back(data_reply(reg_byte_last));
        replies_due.push_back(status_reply(StatusOk));
      end
      CMD_ADD_CHARGE: begin
        replies_due.push_back(status_reply(StatusOk));
      end
      default: begin
        replies_due.push_back(status_reply(StatusErr));
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreBytes; i++) card_store[i] = EraseByte;
      staged_count = 0;
      reg_bytes_low = '0;
      reg_byte_last = '0;
      replies_due.delete();
      mismatches_o = 0;
      replies_pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("reply beat with nothing awaited: has_data %0d data_out 0x%0h status 0x%0h",
                 has_data_i, data_out_i, status_i);
          mismatches_o++;
        end else begin
          oldest_reply = replies_due.pop_front();
          check_field("has_data", oldest_reply.has_data, has_data_i);
          check_field("data_out", oldest_reply.data_out, data_out_i);
          check_field("status", oldest_reply.status, status_i);
          check_field("end_of_response", oldest_reply.end_of_response, end_of_response_i);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == RegLowAddr) reg_bytes_low = pwdata;
        else if (paddr == RegLastAddr) reg_byte_last = pwdata[7:0];
      end
      if (in_valid_i && in_ready_i) take_card_beat(cmd_i, record_i, data_byte_i, last_i);
      replies_pending_o = replies_due.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pbcs_pkg::*;

  localparam logic [3:0] RegLowAddr  = 4'd0;
  localparam logic [3:0] RegLastAddr = 4'd8;
  localparam logic [2:0] CmdUnsupLo  = 3'd4;
  localparam logic [2:0] CmdUnsupHi  = 3'd7;
  localparam int SettleCycles = 64;
  localparam int HoldCycles   = 300;
  // Longest quiet spell is the clearing pass after reset or the long receiver hold.
  localparam int StallLimit   = 8000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [7:0]  record_i;
  logic [7:0]  data_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        has_data_o;
  logic [7:0]  data_out_o;
  logic [7:0]  status_o;
  logic        end_of_response_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int mismatches;
  int replies_pending;
  int beats_sent;
  int quiet_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  phonebook_card_command_store dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .record_i          (record_i),
    .data_byte_i       (data_byte_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .has_data_o        (has_data_o),
    .data_out_o        (data_out_o),
    .status_o          (status_o),
    .end_of_response_o (end_of_response_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  phonebook_reply_checker #(
    .RegLowAddr  (RegLowAddr),
    .RegLastAddr (RegLastAddr)
  ) replies (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .cmd_i             (cmd_i),
    .record_i          (record_i),
    .data_byte_i       (data_byte_i),
    .last_i            (last_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .has_data_i        (has_data_o),
    .data_out_i        (data_out_o),
    .status_i          (status_o),
    .end_of_response_i (end_of_response_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatches_o      (mismatches),
    .replies_pending_o (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reply side: short random stalls, and one long hold when asked for.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input logic [63:0] low_bytes, input logic [7:0] last_byte);
    write_reg(RegLowAddr, low_bytes);
    write_reg(RegLastAddr, {56'd0, last_byte});
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] rec,
                           input logic [7:0] db, input logic lst);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    record_i = rec;
    data_byte_i = db;
    last_i = lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic send_other(input logic [2:0] cmd, input logic [7:0] rec);
    send_beat(cmd, rec, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_record_write(input logic [7:0] rec, input int beats,
                                   input bit blank_name, input bit closed);
    logic [7:0] b;
    int         k;
    for (k = 0; k < beats; k++) begin
      b = 8'($urandom);
      if (k == NameStart) b = blank_name ? BlankChar : ((b == BlankChar) ? ~b : b);
      if (k == beats - 1) send_beat(CMD_WRITE_RECORD, rec, b, closed);
      else send_beat(CMD_WRITE_RECORD, 8'($urandom), b, 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_record();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'(0);
    if (roll == 1) return 8'($urandom_range(MaxEntry + 1, 255));
    return 8'($urandom_range(1, MaxEntry));
  endfunction

  task automatic random_command();
    int roll;
    int beats;
    bit closed;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      send_record_write(pick_record(), RecBytes, $urandom_range(0, 3) == 0, 1'b1);
    end else if (roll < 45) begin
      // Short, long or unterminated write sequences.
      closed = $urandom_range(0, 2) != 0;
      beats = $urandom_range(1, RecBytes + 2);
      if (closed && beats == RecBytes) beats++;
      send_record_write(pick_record(), beats, 1'b0, closed);
    end else if (roll < 75) begin
      send_other(CMD_READ_RECORD, pick_record());
    end else if (roll < 85) begin
      send_other(CMD_READ_REG, 8'($urandom));
    end else if (roll < 92) begin
      send_other(CMD_ADD_CHARGE, 8'($urandom));
    end else begin
      send_other(3'($urandom_range(CmdUnsupLo, CmdUnsupHi)), 8'($urandom));
    end
  endtask

  task automatic run_random(input int beat_target);
    while (beats_sent < beat_target) random_command();
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (replies_pending != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0;
    record_i = '0;
    data_byte_i = '0;
    last_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    beats_sent = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    configure('0, '0);
    send_other(CMD_READ_RECORD, 8'(0));
    send_other(CMD_READ_RECORD, 8'(MaxEntry));
    send_other(CMD_READ_RECORD, 8'(MaxEntry + 1));
    send_other(CMD_READ_RECORD, 8'hFF);
    send_other(CMD_READ_REG, 8'h00);
    send_other(CMD_ADD_CHARGE, 8'hFF);
    send_other(CmdUnsupLo, 8'h00);
    send_other(CmdUnsupHi, 8'hFF);
    // A lone closing beat is a count error; an open write cut short by another command.
    send_beat(CMD_WRITE_RECORD, 8'(3), 8'h00, 1'b1);
    send_beat(CMD_WRITE_RECORD, 8'(4), 8'hFF, 1'b0);
    send_beat(CMD_WRITE_RECORD, 8'(4), 8'h5A, 1'b0);
    send_other(CMD_ADD_CHARGE, 8'(4));
    drain();

    configure('1, 8'hFF);
    run_random(130);
    drain();

    configure({$urandom, $urandom}, 8'($urandom));
    tx_idle_on = 1'b0;
    // Stall the reply side for a long while so the command queue backs up.
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    run_random(250);
    drain();

    configure({$urandom, $urandom}, 8'($urandom));
    rx_idle_on = 1'b0;
    run_random(370);
    drain();

    if (mismatches == 0 && replies_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pbcs_pkg.sv
src/pbcs_fifo.sv
src/pbcs_front.sv
src/pbcs_back.sv
src/phonebook_card_command_store.sv
verif/phonebook_reply_checker.sv
verif/tb_top.sv
